// ===== design/thermistor_resistance_to_temperature_top_macros.svh =====
// Assertion macros for the thermistor converter checker
`ifndef THERMISTOR_RESISTANCE_TO_TEMPERATURE_TOP_MACROS_SVH
`define THERMISTOR_RESISTANCE_TO_TEMPERATURE_TOP_MACROS_SVH
// implication checked every clock outside reset
`define CHK_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("check failed");
// next-cycle implication
`define CHK_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("check failed");
`endif

// ===== design/thr_pkg.sv =====
// Shared types and constants for the thermistor converter
package thr_pkg;
  localparam int RES_BITS_DEF = 24;
  localparam int FRAC_BITS = 24;
  localparam logic [31:0] LN2_Q32 = 32'd2977044472;
  localparam logic [47:0] COEF_A_RST = 48'd284073000000;
  localparam logic [47:0] COEF_B_RST = 48'd66945000000;
  localparam logic [47:0] COEF_C_RST = 48'd56834000;
  localparam logic [1:0] CFG_COEF_A = 2'd0;
  localparam logic [1:0] CFG_COEF_B = 2'd1;
  localparam logic [1:0] CFG_COEF_C = 2'd2;

  typedef enum logic [1:0] {
    ST_OK = 2'd0,
    ST_ZERO = 2'd1,
    ST_RANGE = 2'd2
  } status_t;
endpackage

// ===== design/thr_log.sv =====
// Pipelined log2 of the resistance: one fraction bit per stage, then scaling to ln
module thr_log #(
  parameter int RES_BITS = thr_pkg::RES_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_vld,
  input  logic [RES_BITS-1:0] in_r,
  output logic                out_vld,
  output logic                out_zero,
  output logic [28:0]         out_ln
);
  import thr_pkg::*;
  localparam int NB = $clog2(RES_BITS);
  localparam int NS = FRAC_BITS + 1;

  logic [NS-1:0]    vld_r;
  logic [NS-1:0]    zero_r;
  logic [32:0]      m_r  [NS];
  logic [28:0]      lg_r [NS];
  logic [60:0]      prod_r;
  logic             pv_r, pz_r;
  logic [NB-1:0]    n_c;
  logic [4:0]       n5_c;

  // top set bit of the input
  always_comb begin
    n_c = '0;
    for (int i = 0; i < RES_BITS; i++) begin
      if (in_r[i]) n_c = NB'(i);
    end
    n5_c = 5'(n_c);
  end

  // stage 0 normalizes; stages 1..24 each make one fraction bit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      pv_r  <= 1'b0;
    end else if (en) begin
      vld_r <= {vld_r[NS-2:0], in_vld};
      pv_r  <= vld_r[NS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      zero_r[0] <= (in_r == '0);
      m_r[0]    <= 33'(({32'd0, in_r} << (31 - n5_c)));
      lg_r[0]   <= {n5_c, 24'd0};
      for (int s = 1; s < NS; s++) begin
        logic [65:0] sq;
        logic [32:0] mq;
        sq = 66'(m_r[s-1]) * 66'(m_r[s-1]);
        mq = sq[63:31];
        zero_r[s] <= zero_r[s-1];
        if (mq[32]) begin
          m_r[s]  <= mq >> 1;
          lg_r[s] <= lg_r[s-1] | (29'd1 << (FRAC_BITS - s));
        end else begin
          m_r[s]  <= mq;
          lg_r[s] <= lg_r[s-1];
        end
      end
      prod_r <= 61'(lg_r[NS-1]) * 61'(LN2_Q32) + 61'h80000000;
      pz_r   <= zero_r[NS-1];
    end
  end

  assign out_vld  = pv_r;
  assign out_zero = pz_r;
  assign out_ln   = prod_r[60:32];
endmodule

// ===== design/thr_poly.sv =====
// Pipelined denominator D = A + B*L + C*L^3, in Q.48
module thr_poly (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_vld,
  input  logic               in_zero,
  input  logic [28:0]        in_ln,
  input  logic signed [47:0] coef_a,
  input  logic signed [47:0] coef_b,
  input  logic signed [47:0] coef_c,
  output logic               out_vld,
  output logic               out_zero,
  output logic signed [65:0] out_d
);
  import thr_pkg::*;
  logic [4:0]  vld_r;
  logic [4:0]  z_r;
  logic [28:0] l1_r;
  logic [33:0] sq_r;
  logic [37:0] cu_r;
  logic signed [53:0] bh_r;
  logic [52:0] blo_r;
  logic signed [62:0] ch_r;
  logic [61:0] clo_r;
  logic signed [96:0] bl_r, bl2_r, cl_r;
  logic signed [65:0] d_r;

  function automatic logic signed [65:0] tr24(input logic signed [96:0] p);
    logic signed [96:0] q;
    q = (p < 0) ? -((-p) >>> 24) : (p >>> 24);
    return q[65:0];
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else if (en) vld_r <= {vld_r[3:0], in_vld};
  end

  // coefficients are split at bit 24 so each multiplier stays near 32 bits
  always_ff @(posedge clk) begin
    if (en) begin
      z_r   <= {z_r[3:0], in_zero};
      // stage 1: L and L^2
      l1_r  <= in_ln;
      sq_r  <= 34'((58'(in_ln) * 58'(in_ln)) >> 24);
      // stage 2: L^3, partial products of B*L
      cu_r  <= 38'((63'(sq_r) * 63'(l1_r)) >> 24);
      bh_r  <= 54'($signed(coef_b[47:24])) * 54'($signed({1'b0, l1_r}));
      blo_r <= 53'(coef_b[23:0]) * 53'(l1_r);
      // stage 3: partial products of C*L^3, B*L recombined
      ch_r  <= 63'($signed(coef_c[47:24])) * 63'($signed({1'b0, cu_r}));
      clo_r <= 62'(coef_c[23:0]) * 62'(cu_r);
      bl_r  <= (97'(bh_r) <<< 24) + 97'(blo_r);
      // stage 4: C*L^3 recombined
      cl_r  <= (97'(ch_r) <<< 24) + 97'(clo_r);
      bl2_r <= bl_r;
      // stage 5: sum
      d_r   <= 66'($signed(coef_a)) + tr24(bl2_r) + tr24(cl_r);
    end
  end

  assign out_vld  = vld_r[4];
  assign out_zero = z_r[4];
  assign out_d    = d_r;
endmodule

// ===== design/thr_recip.sv =====
// Pipelined rounded reciprocal K = round(2^56 / D), two quotient bits per stage
module thr_recip (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_vld,
  input  logic [1:0]         in_code,
  input  logic [65:0]        in_d,
  output logic               out_vld,
  output logic [1:0]         out_code,
  output logic               out_sat,
  output logic [19:0]        out_k
);
  import thr_pkg::*;
  localparam int QB = 22;
  localparam int NS = QB / 2;
  // quotient of (2^57 + D) / (2D) equals round(2^56/D); big D gives small q
  logic [NS:0]  vld_r;
  logic [1:0]   code_r [NS+1];
  logic [67:0]  dv_r   [NS+1];
  logic [67:0]  rem_r  [NS+1];
  logic [QB-1:0] q_r   [NS+1];
  logic         big_r  [NS+1];

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else if (en) vld_r <= {vld_r[NS-1:0], in_vld};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      logic [67:0] num;
      num = (68'd1 << 57) + 68'(in_d);
      code_r[0] <= in_code;
      dv_r[0]   <= 68'({in_d, 1'b0});
      // quotient must fit QB bits, else it saturates anyway
      big_r[0]  <= (num >> QB) >= {in_d, 1'b0};
      rem_r[0]  <= num;
      q_r[0]    <= '0;
      for (int s = 1; s <= NS; s++) begin
        logic [67:0] r;
        logic [QB-1:0] q;
        int sh;
        r = rem_r[s-1];
        q = q_r[s-1];
        for (int j = 0; j < 2; j++) begin
          sh = QB - 1 - (2*(s-1) + j);
          if ((r >> sh) >= dv_r[s-1]) begin
            r = r - (dv_r[s-1] << sh);
            q[sh] = 1'b1;
          end
        end
        rem_r[s]  <= r;
        q_r[s]    <= q;
        dv_r[s]   <= dv_r[s-1];
        code_r[s] <= code_r[s-1];
        big_r[s]  <= big_r[s-1];
      end
    end
  end

  assign out_vld  = vld_r[NS];
  assign out_code = code_r[NS];
  assign out_sat  = big_r[NS] || (q_r[NS] > QB'(20'hFFFFF));
  assign out_k    = out_sat ? 20'hFFFFF : q_r[NS][19:0];
endmodule

// ===== design/thr_conv.sv =====
// Kelvin to celsius and fahrenheit with rounding and saturation, three stages
module thr_conv (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_vld,
  input  logic [1:0]         in_code,
  input  logic               in_sat,
  input  logic [19:0]        in_k,
  output logic               out_vld,
  output logic [19:0]        out_k,
  output logic signed [19:0] out_c,
  output logic signed [20:0] out_f,
  output logic [1:0]         out_st
);
  import thr_pkg::*;
  // floor(m/5) = (m*RECIP5) >> 26 and floor(m/25) = (m*RECIP25) >> 31, exact for m < 2^26
  localparam logic [23:0] RECIP5  = 24'd13421773;
  localparam logic [26:0] RECIP25 = 27'd85899346;
  localparam logic signed [27:0] KELVIN_OFS = 28'sd349632;

  logic [2:0] vld_r;
  logic [1:0] code_r, code2_r;
  logic       sat_r, sat2_r;
  logic [19:0] k_r, k2_r, k3_r;
  logic       neg_r, neg2_r;
  logic [23:0] cm_r;
  logic [25:0] fm_r;
  logic [47:0] cp_r;
  logic [52:0] fp_r;
  logic signed [19:0] c_r;
  logic signed [20:0] f_r;
  logic [1:0] st_r;
  logic signed [27:0] c5_c;
  logic [27:0] mag_c;

  // five times celsius, and its magnitude for half-away rounding
  always_comb begin
    c5_c  = 28'sd5 * $signed({8'd0, in_k}) - KELVIN_OFS;
    mag_c = (c5_c < 0) ? 28'(-c5_c) : 28'(c5_c);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else if (en) vld_r <= {vld_r[1:0], in_vld};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      logic signed [27:0] c, f;
      logic [1:0] st;
      // stage 1: rounding magnitudes
      code_r <= in_code;
      sat_r  <= in_sat;
      k_r    <= in_k;
      neg_r  <= (c5_c < 0);
      cm_r   <= 24'(mag_c + 28'd2);
      fm_r   <= 26'(mag_c * 28'd9 + 28'd12);
      // stage 2: divide by 5 and 25 through reciprocal products
      code2_r <= code_r;
      sat2_r  <= sat_r;
      k2_r    <= k_r;
      neg2_r  <= neg_r;
      cp_r    <= 48'(cm_r) * 48'(RECIP5);
      fp_r    <= 53'(fm_r) * 53'(RECIP25);
      // stage 3: restore sign, clamp
      c = $signed(28'(cp_r[47:26]));
      f = $signed(28'(fp_r[52:31]));
      if (neg2_r) begin
        c = -c;
        f = -f;
      end
      f  = f + 28'sd8192;
      st = sat2_r ? ST_RANGE : ST_OK;
      if (c > 28'sd524287) begin c = 28'sd524287; st = ST_RANGE; end
      if (c < -28'sd524288) begin c = -28'sd524288; st = ST_RANGE; end
      if (f > 28'sd1048575) begin f = 28'sd1048575; st = ST_RANGE; end
      if (f < -28'sd1048576) begin f = -28'sd1048576; st = ST_RANGE; end
      if (code2_r != ST_OK) begin
        k3_r <= '0; c_r <= '0; f_r <= '0; st_r <= code2_r;
      end else begin
        k3_r <= k2_r; c_r <= c[19:0]; f_r <= f[20:0]; st_r <= st;
      end
    end
  end

  assign out_vld = vld_r[2];
  assign out_k   = k3_r;
  assign out_c   = c_r;
  assign out_f   = f_r;
  assign out_st  = st_r;
endmodule

// ===== design/thermistor_resistance_to_temperature_top.sv =====
// Top level of the Steinhart-Hart thermistor converter
// Converts one resistance per cycle to kelvin, celsius and fahrenheit. The
// pipeline holds 46 register stages (26 for the log, 5 for the polynomial,
// 12 for the reciprocal, 3 for the output conversion); the whole chain
// advances together and stalls as one when the output is not taken. The user
// must write coefficients through the cfg port only while the block is idle;
// the block itself does not enforce this.
module thermistor_resistance_to_temperature_top #(
  parameter int RESISTANCE_BITS = thr_pkg::RES_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [23:0] in_resistance_ohms,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [19:0] out_temp_kelvin,
  output logic signed [19:0] out_temp_celsius,
  output logic signed [20:0] out_temp_fahrenheit,
  output logic [1:0]  out_status,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [47:0] cfg_wdata
);
  import thr_pkg::*;
  logic [47:0] coef_a_r, coef_b_r, coef_c_r;
  logic en;
  logic lv, lz, pv, pz, rv, rs, cv;
  logic [RESISTANCE_BITS-1:0] res_in;
  logic [28:0] ln;
  logic signed [65:0] d;
  logic [1:0] rcode, pcode, cst;
  logic [19:0] rk, ck;
  logic signed [19:0] cc;
  logic signed [20:0] cf;

  // coefficient registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_a_r <= COEF_A_RST; coef_b_r <= COEF_B_RST; coef_c_r <= COEF_C_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_COEF_A: coef_a_r <= cfg_wdata;
        CFG_COEF_B: coef_b_r <= cfg_wdata;
        CFG_COEF_C: coef_c_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // whole pipe advances when the final register is free
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // only the low RESISTANCE_BITS bits count
  assign res_in = RESISTANCE_BITS'(in_resistance_ohms);

  thr_log #(.RES_BITS(RESISTANCE_BITS)) u_log (
    .clk, .rst_n, .en, .in_vld(in_valid),
    .in_r(res_in),
    .out_vld(lv), .out_zero(lz), .out_ln(ln));

  thr_poly u_poly (
    .clk, .rst_n, .en, .in_vld(lv), .in_zero(lz), .in_ln(ln),
    .coef_a(coef_a_r), .coef_b(coef_b_r), .coef_c(coef_c_r),
    .out_vld(pv), .out_zero(pz), .out_d(d));

  assign pcode = pz ? ST_ZERO : ((d <= 0) ? ST_RANGE : ST_OK);

  thr_recip u_recip (
    .clk, .rst_n, .en, .in_vld(pv), .in_code(pcode),
    .in_d((d <= 0) ? 66'd1 : 66'(d)),
    .out_vld(rv), .out_code(rcode), .out_sat(rs), .out_k(rk));

  thr_conv u_conv (
    .clk, .rst_n, .en, .in_vld(rv), .in_code(rcode), .in_sat(rs), .in_k(rk),
    .out_vld(cv), .out_k(ck), .out_c(cc), .out_f(cf), .out_st(cst));

  assign out_valid           = cv;
  assign out_temp_kelvin     = ck;
  assign out_temp_celsius    = cc;
  assign out_temp_fahrenheit = cf;
  assign out_status          = cst;
endmodule

// ===== design/thr_chk.sv =====
// Port-level checker for the thermistor converter, bound to the top level
`include "thermistor_resistance_to_temperature_top_macros.svh"
module thr_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [19:0] out_temp_kelvin,
  input logic [1:0]  out_status
);
  import thr_pkg::*;
  `CHK_IMPL(a_stat, clk, rst_n, out_valid, out_status != 2'd3)
  `CHK_IMPL(a_zero, clk, rst_n, out_valid && out_status == ST_ZERO, out_temp_kelvin == 20'd0)
  `CHK_IMPL(a_rdy, clk, rst_n, out_valid && !out_ready, !in_ready)
  `CHK_NEXT(a_hold, clk, rst_n, out_valid && !out_ready, out_valid)
endmodule

bind thermistor_resistance_to_temperature_top thr_chk u_chk (.*);

// ===== tb/thermistor_checker.sv =====
// Checker for the thermistor converter: watches transfers, predicts temperatures, compares
module thermistor_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [23:0]        in_resistance_ohms,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [19:0]        out_temp_kelvin,
  input  logic signed [19:0] out_temp_celsius,
  input  logic signed [20:0] out_temp_fahrenheit,
  input  logic [1:0]         out_status,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [47:0]        cfg_wdata,
  output int                 fail_count,
  output int                 pending_count
);
  timeunit 1ns;
  timeprecision 1ps;
  import thr_pkg::*;

  typedef struct packed {
    logic [19:0] kelvin;
    logic [19:0] celsius;
    logic [20:0] fahrenheit;
    status_t     status;
  } temps_t;

  logic signed [47:0] shadow_a, shadow_b, shadow_c;
  temps_t expected_temps[$];

  // natural log in Q5.24
  function automatic logic [63:0] ln_fixed(input logic [63:0] r);
    int top;
    logic [63:0] m, lg;
    logic [127:0] prod;
    top = 0;
    for (int i = 0; i < RES_BITS_DEF; i++) if (r[i]) top = i;
    m = r << (31 - top);
    lg = 64'(top) << FRAC_BITS;
    for (int i = 0; i < FRAC_BITS; i++) begin
      m = (m * m) >> 31;
      if (m >= 64'h1_0000_0000) begin
        lg[FRAC_BITS-1-i] = 1'b1;
        m = m >> 1;
      end
    end
    prod = 128'(lg) * 128'(LN2_Q32) + 128'h8000_0000;
    return 64'(prod >> 32);
  endfunction

  // signed times unsigned, shift 24, truncate toward zero
  function automatic longint scaled_product(input logic signed [47:0] a, input logic [63:0] u);
    logic [127:0] mag, p;
    mag = (a < 0) ? 128'(-longint'(a)) : 128'(longint'(a));
    p = (mag * 128'(u)) >> 24;
    return (a < 0) ? -longint'(p[63:0]) : longint'(p[63:0]);
  endfunction

  function automatic longint round_half_away(input longint x, input longint d);
    if (x >= 0) return (x + d / 2) / d;
    return -((-x + d / 2) / d);
  endfunction

  function automatic temps_t convert_resistance(input logic [23:0] ohms);
    temps_t t;
    logic [63:0] l, l2, l3, ud, k;
    longint d, c5, c, f;
    t = '0;
    t.status = ST_OK;
    if (ohms == 0) begin
      t.status = ST_ZERO;
      return t;
    end
    l = ln_fixed(64'(ohms));
    l2 = (l * l) >> FRAC_BITS;
    l3 = (l2 * l) >> FRAC_BITS;
    d = longint'(shadow_a) + scaled_product(shadow_b, l) + scaled_product(shadow_c, l3);
    if (d <= 0) begin
      t.status = ST_RANGE;
      return t;
    end
    ud = 64'(d);
    k = ((64'd1 << 56) + ud / 2) / ud;
    if (k > 64'd1048575) begin
      k = 64'd1048575;
      t.status = ST_RANGE;
    end
    c5 = 5 * longint'(k) - 349632;
    c = round_half_away(c5, 5);
    f = round_half_away(c5 * 9, 25) + 8192;
    if (c > 524287) begin c = 524287; t.status = ST_RANGE; end
    if (c < -524288) begin c = -524288; t.status = ST_RANGE; end
    if (f > 1048575) begin f = 1048575; t.status = ST_RANGE; end
    if (f < -1048576) begin f = -1048576; t.status = ST_RANGE; end
    t.kelvin = k[19:0];
    t.celsius = c[19:0];
    t.fahrenheit = f[20:0];
    return t;
  endfunction

  assign pending_count = expected_temps.size();

  always @(posedge clk) begin
    temps_t want;
    int errs;
    if (!rst_n) begin
      shadow_a <= COEF_A_RST;
      shadow_b <= COEF_B_RST;
      shadow_c <= COEF_C_RST;
      expected_temps.delete();
      fail_count <= 0;
    end else begin
      errs = 0;
      // register writes
      if (cfg_we) begin
        case (cfg_index)
          CFG_COEF_A: shadow_a <= cfg_wdata;
          CFG_COEF_B: shadow_b <= cfg_wdata;
          CFG_COEF_C: shadow_c <= cfg_wdata;
          default: ;
        endcase
      end
      // input transfer
      if (in_valid && in_ready) expected_temps.push_back(convert_resistance(in_resistance_ohms));
      // result transfer
      if (out_valid && out_ready) begin
        if (expected_temps.size() == 0) begin
          $error("result transfer with nothing expected");
          errs++;
        end else begin
          want = expected_temps.pop_front();
          if (want.kelvin !== out_temp_kelvin) begin
            $error("temp_kelvin exp %0d got %0d", want.kelvin, out_temp_kelvin);
            errs++;
          end
          if (want.celsius !== out_temp_celsius) begin
            $error("temp_celsius exp %0d got %0d", $signed(want.celsius), out_temp_celsius);
            errs++;
          end
          if (want.fahrenheit !== out_temp_fahrenheit) begin
            $error("temp_fahrenheit exp %0d got %0d", $signed(want.fahrenheit),
                   out_temp_fahrenheit);
            errs++;
          end
          if (want.status !== out_status) begin
            $error("status exp %0d got %0d", want.status, out_status);
            errs++;
          end
        end
      end
      if (errs != 0) fail_count <= fail_count + errs;
    end
  end
endmodule

// ===== tb/tb_top.sv =====
// Testbench top for the thermistor converter: stimulus, configuration phases, verdict
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import thr_pkg::*;

  localparam int PIPE_DRAIN = 80;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [23:0] in_resistance_ohms = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [19:0] out_temp_kelvin;
  logic signed [19:0] out_temp_celsius;
  logic signed [20:0] out_temp_fahrenheit;
  logic [1:0] out_status;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [47:0] cfg_wdata = '0;
  int fail_count, pending_count;
  bit stall_enable = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  thermistor_resistance_to_temperature_top u_dut (.*);

  thermistor_checker u_checker (.*);

  // random idle length, mostly short with an occasional long one
  function automatic int idle_len();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 50) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // result side back-pressure
  always @(posedge clk) begin
    if (!stall_enable) out_ready <= 1'b1;
    else out_ready <= ($urandom_range(0, 99) < 70);
  end

  // valid stays high between back-to-back transfers; it drops only for a gap
  task automatic send_resistance(input logic [23:0] ohms);
    int gap;
    gap = stall_enable ? idle_len() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_resistance_ohms <= ohms;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (PIPE_DRAIN) @(posedge clk);
  endtask

  // registers change only with the pipeline empty
  task automatic write_coef(input logic [1:0] idx, input logic [47:0] value);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // resistances biased toward typical values, with wide and edge values mixed in
  function automatic logic [23:0] rand_resistance();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll < 5) return 24'($urandom_range(500, 200000));
    if (roll < 8) return 24'($urandom());
    if (roll < 9) return 24'($urandom_range(0, 16));
    return 24'hFFFFFF - 24'($urandom_range(0, 16));
  endfunction

  task automatic random_burst(input int count);
    for (int i = 0; i < count; i++) send_resistance(rand_resistance());
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: field extremes, zero resistance, bit walk
    send_resistance(24'd0);
    send_resistance(24'd1);
    send_resistance(24'd2);
    send_resistance(24'd10000);
    send_resistance(24'hFFFFFF);
    send_resistance(24'hAAAAAA);
    send_resistance(24'h555555);
    for (int b = 0; b < 24; b += 2) send_resistance(24'd1 << b);
    drain();

    // non-positive denominator and kelvin overflow
    write_coef(CFG_COEF_A, 48'h800000000000);
    write_coef(CFG_COEF_B, '0);
    write_coef(CFG_COEF_C, '0);
    send_resistance(24'd1000);
    write_coef(CFG_COEF_A, '0);
    send_resistance(24'd1000);
    send_resistance(24'd1);
    write_coef(CFG_COEF_A, 48'd1);
    send_resistance(24'd5);
    drain();

    // extremes of all registers, then random phases
    stall_enable = 1'b1;
    write_coef(CFG_COEF_A, 48'h7FFFFFFFFFFF);
    write_coef(CFG_COEF_B, 48'h7FFFFFFFFFFF);
    write_coef(CFG_COEF_C, 48'h7FFFFFFFFFFF);
    random_burst(60);
    drain();
    write_coef(CFG_COEF_A, 48'h800000000000);
    write_coef(CFG_COEF_B, 48'h800000000000);
    write_coef(CFG_COEF_C, 48'h800000000000);
    random_burst(60);
    drain();
    for (int p = 0; p < 6; p++) begin
      write_coef(CFG_COEF_A, 48'($urandom_range(0, 1)) ? {$urandom(), 16'($urandom())}
                 : COEF_A_RST + 48'($urandom_range(0, 1 << 30)));
      write_coef(CFG_COEF_B, {$urandom(), 16'($urandom())} >> $urandom_range(0, 20));
      write_coef(CFG_COEF_C, {$urandom(), 16'($urandom())} >> $urandom_range(0, 30));
      random_burst(90);
      drain();
    end
    write_coef(CFG_COEF_A, COEF_A_RST);
    write_coef(CFG_COEF_B, COEF_B_RST);
    write_coef(CFG_COEF_C, COEF_C_RST);
    random_burst(600);
    // a stretch with no idling on either side
    stall_enable = 1'b0;
    random_burst(50);
    drain();

    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #3ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule
